/* hw/rtl/sar_adc_triggered_histogram_assert.svh */
// Assertion macros used by the histogram converter checker
`ifndef SAR_ADC_TRIGGERED_HISTOGRAM_ASSERT_SVH
`define SAR_ADC_TRIGGERED_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define SATH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sath assertion failed");

// Next-cycle implication, disabled while reset is high
`define SATH_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sath assertion failed");

`endif

/* hw/rtl/sath_pkg.sv */
// Shared constants, codes and types of the triggered histogram converter
`timescale 1ns / 1ps
package sath_pkg;

   localparam int DAC_BITS_DEF    = 12;
   localparam int BIN_SHIFT_DEF   = 3;
   localparam int COUNT_WIDTH_DEF = 20;

   localparam int HIST_AW    = 9;
   localparam int HIST_DEPTH = 1 << HIST_AW;

   localparam int                 LIMIT_W     = 20;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd200000;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 20;

   localparam int                STEP_W     = 5;
   localparam logic [STEP_W-1:0] FIRST_STEP = 5'd2;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_READ    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EDGE_RISE = 2'd0,
      EDGE_FALL = 2'd1,
      EDGE_ANY  = 2'd2
   } edge_type;

   typedef enum logic [1:0] {
      CAP_EMPTY = 2'd0,
      CAP_RUN   = 2'd1,
      CAP_FULL  = 2'd2
   } cap_status_type;

   typedef enum logic [1:0] {
      CSR_TRIG_LEVEL   = 2'd0,
      CSR_TRIG_DELTA   = 2'd1,
      CSR_TRIG_EDGE    = 2'd2,
      CSR_SAMPLE_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_BUMP,
      FSM_READ,
      FSM_CLEAR
   } fsm_type;

   // Histogram increment request from the capture logic
   typedef struct packed {
      logic               en;
      logic [HIST_AW-1:0] bin;
   } bump_type;

endpackage

/* hw/rtl/sath_hist_ram.sv */
// Histogram count memory: one write port, one read port with registered data
`timescale 1ns / 1ps
module sath_hist_ram #(
   parameter int COUNT_WIDTH = sath_pkg::COUNT_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [sath_pkg::HIST_AW-1:0] wr_addr,
   input  logic [COUNT_WIDTH-1:0]       wr_data,
   input  logic [sath_pkg::HIST_AW-1:0] rd_addr,
   output logic [COUNT_WIDTH-1:0]       rd_data
);
   import sath_pkg::*;

   logic [COUNT_WIDTH-1:0] mem [HIST_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* hw/rtl/sath_sar.sv */
// Successive-approximation register: one trial step per conversion tick
`timescale 1ns / 1ps
module sath_sar #(
   parameter int DAC_BITS = sath_pkg::DAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                tick,
   input  logic                comp,
   output logic [DAC_BITS-1:0] cur_code,
   output logic [DAC_BITS-1:0] next_code,
   output logic                done,
   output logic [DAC_BITS-1:0] sample
);
   import sath_pkg::*;

   localparam int AW = DAC_BITS + 1;
   localparam int SW = DAC_BITS + 2;
   localparam logic [AW-1:0]     FULL = AW'(1) << DAC_BITS;
   localparam logic [AW-1:0]     MID  = AW'(1) << (DAC_BITS - 1);
   localparam logic [STEP_W-1:0] LAST = STEP_W'(DAC_BITS + 1);

   logic [AW-1:0]     approx_ff, approx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last;
   logic [AW-1:0]     half;
   logic [SW-1:0]     sum;
   logic [AW-1:0]     new_approx;

   function automatic logic [DAC_BITS-1:0] clamp_code(input logic [AW-1:0] v);
      return v[DAC_BITS] ? {DAC_BITS{1'b1}} : v[DAC_BITS-1:0];
   endfunction

   always_comb begin
      last = (step_ff == LAST);
      half = FULL >> step_ff;
      if (!comp) begin
         sum = {1'b0, approx_ff} - {1'b0, half} - {{AW{1'b0}}, last};
      end else if (!last) begin
         sum = {1'b0, approx_ff} + {1'b0, half};
      end else begin
         sum = {1'b0, approx_ff};
      end
      // clamp to 0 .. full scale
      if (sum[SW-1]) begin
         new_approx = '0;
      end else if (sum[AW-1:0] > FULL) begin
         new_approx = FULL;
      end else begin
         new_approx = sum[AW-1:0];
      end
   end

   assign done      = last;
   assign sample    = clamp_code(new_approx);
   assign cur_code  = clamp_code(approx_ff);
   assign next_code = last ? MID[DAC_BITS-1:0] : clamp_code(new_approx);

   always_comb begin
      approx_in = approx_ff;
      step_in   = step_ff;
      if (tick) begin
         approx_in = last ? MID : new_approx;
         step_in   = last ? FIRST_STEP : step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         approx_ff <= MID;
         step_ff   <= FIRST_STEP;
      end else begin
         approx_ff <= approx_in;
         step_ff   <= step_in;
      end
   end

endmodule

/* hw/rtl/sath_capture.sv */
// Trigger, capture status and sample counter for finished samples
`timescale 1ns / 1ps
module sath_capture #(
   parameter int DAC_BITS  = sath_pkg::DAC_BITS_DEF,
   parameter int BIN_SHIFT = sath_pkg::BIN_SHIFT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            sample_en,
   input  logic [DAC_BITS-1:0]             sample,
   input  logic                            button,
   input  logic                            restart,
   input  logic [DAC_BITS-1:0]             trig_level,
   input  logic [DAC_BITS-1:0]             trig_delta,
   input  logic [1:0]                      trig_edge,
   input  logic [sath_pkg::LIMIT_W-1:0]    sample_limit,
   output sath_pkg::cap_status_type        status_next,
   output sath_pkg::bump_type              bump
);
   import sath_pkg::*;

   localparam int SW = DAC_BITS + 2;
   localparam int XW = DAC_BITS + HIST_AW;

   logic [DAC_BITS-1:0] prev_ff, prev_in;
   logic                armed_ff, armed_in;
   cap_status_type      status_ff, status_in;
   logic [LIMIT_W-1:0]  taken_ff, taken_in;

   logic                edge_hit, fire, in_window;
   logic signed [SW-1:0] sx, lo, hi;
   logic [LIMIT_W-1:0]  taken_inc;
   logic [XW-1:0]       bin_ext;

   always_comb begin
      edge_hit = ((trig_edge == EDGE_RISE) && (prev_ff < sample))
              || ((trig_edge == EDGE_FALL) && (prev_ff > sample))
              || ((trig_edge == EDGE_ANY)  && (prev_ff != sample));
      fire      = button || (armed_ff && edge_hit);
      sx        = signed'(SW'(sample));
      lo        = signed'(SW'(trig_level)) - signed'(SW'(trig_delta));
      hi        = signed'(SW'(trig_level)) + signed'(SW'(trig_delta));
      in_window = (sx > lo) && (sx < hi);
      taken_inc = taken_ff + LIMIT_W'(1);
      bin_ext   = XW'(sample) >> BIN_SHIFT;
   end

   always_comb begin
      prev_in   = prev_ff;
      armed_in  = armed_ff;
      status_in = status_ff;
      taken_in  = taken_ff;
      if (restart) begin
         armed_in  = 1'b0;
         status_in = CAP_EMPTY;
         taken_in  = '0;
      end else if (sample_en) begin
         prev_in = sample;
         case (status_ff)
            CAP_RUN: begin
               if (taken_inc >= sample_limit) begin
                  status_in = CAP_FULL;
                  taken_in  = '0;
               end else begin
                  taken_in = taken_inc;
               end
            end
            CAP_EMPTY: begin
               if (fire) begin
                  status_in = CAP_RUN;
                  armed_in  = 1'b0;
               end else begin
                  armed_in = in_window;
               end
            end
            default: ;
         endcase
      end
   end

   assign status_next = status_in;
   assign bump.en     = sample_en && (status_ff == CAP_RUN);
   assign bump.bin    = bin_ext[HIST_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         armed_ff  <= 1'b0;
         status_ff <= CAP_EMPTY;
         taken_ff  <= '0;
      end else begin
         prev_ff   <= prev_in;
         armed_ff  <= armed_in;
         status_ff <= status_in;
         taken_ff  <= taken_in;
      end
   end

endmodule

/* hw/rtl/sar_adc_triggered_histogram.sv */
// Top level: SAR converter with triggered histogram of finished samples
// Results: a tick, restart or ignored operation is pushed into the result queue in the transfer
//   cycle, a bin read from FSM_READ after the registered memory read.
// Throughput: one tick per cycle while req_stall is low; a tick that bins a sample while running
//   passes FSM_BUMP (read then write of one histogram entry); a restart clears all 512 entries.
// Reset: control state returns to its initial values and a clearing pass zeroes the histogram,
//   with req_stall high throughout; configuration writes are taken at any time outside reset.
`timescale 1ns / 1ps
module sar_adc_triggered_histogram #(
   parameter int DAC_BITS    = sath_pkg::DAC_BITS_DEF,
   parameter int BIN_SHIFT   = sath_pkg::BIN_SHIFT_DEF,
   parameter int COUNT_WIDTH = sath_pkg::COUNT_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic                         req_comparator_high,
   input  logic                         req_button,
   input  logic [sath_pkg::HIST_AW-1:0] req_bin_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [DAC_BITS-1:0]          rsp_dac_code,
   output logic                         rsp_sample_valid,
   output logic [DAC_BITS-1:0]          rsp_sample_value,
   output logic [1:0]                   rsp_run_status,
   output logic [COUNT_WIDTH-1:0]       rsp_bin_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sath_pkg::CSR_AW-1:0]  csr_index,
   input  logic [sath_pkg::CSR_DW-1:0]  csr_data
);
   import sath_pkg::*;

   localparam logic [DAC_BITS-1:0] LEVEL_RESET = DAC_BITS'(1) << (DAC_BITS - 1);

   typedef struct packed {
      logic [DAC_BITS-1:0]    dac_code;
      logic                   sample_valid;
      logic [DAC_BITS-1:0]    sample_value;
      logic [1:0]             run_status;
      logic [COUNT_WIDTH-1:0] bin_count;
   } rsp_type;

   // configuration
   logic [DAC_BITS-1:0] trig_level_ff, trig_delta_ff;
   logic [1:0]          trig_edge_ff;
   logic [LIMIT_W-1:0]  sample_limit_ff;

   // control
   fsm_type             fsm_ff, fsm_in;
   logic [HIST_AW-1:0]  clr_idx_ff, clr_idx_in;
   logic [HIST_AW-1:0]  bump_bin_ff;
   logic [1:0]          q_cnt_ff, q_cnt_in;
   rsp_type             head_ff, skid_ff, new_rsp;

   logic                accept, pop, push;
   op_type              op;
   logic                tick, restart;

   logic [DAC_BITS-1:0] cur_code, next_code, sample;
   logic                done;
   cap_status_type      status_next;
   bump_type            bump;

   logic                   wr_en;
   logic [HIST_AW-1:0]     wr_addr, rd_addr;
   logic [COUNT_WIDTH-1:0] wr_data, rd_data, sat_count;

   assign op        = op_type'(req_operation);
   assign req_stall = (fsm_ff != FSM_IDLE) || (q_cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && (op == OP_TICK);
   assign restart   = accept && (op == OP_RESTART);
   assign csr_ready = 1'b1;

   sath_sar #(
      .DAC_BITS (DAC_BITS)
   ) u_sar (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .comp      (req_comparator_high),
      .cur_code  (cur_code),
      .next_code (next_code),
      .done      (done),
      .sample    (sample)
   );

   sath_capture #(
      .DAC_BITS  (DAC_BITS),
      .BIN_SHIFT (BIN_SHIFT)
   ) u_capture (
      .clock        (clock),
      .reset        (reset),
      .sample_en    (tick && done),
      .sample       (sample),
      .button       (req_button),
      .restart      (restart),
      .trig_level   (trig_level_ff),
      .trig_delta   (trig_delta_ff),
      .trig_edge    (trig_edge_ff),
      .sample_limit (sample_limit_ff),
      .status_next  (status_next),
      .bump         (bump)
   );

   sath_hist_ram #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_level_ff   <= LEVEL_RESET;
         trig_delta_ff   <= '0;
         trig_edge_ff    <= EDGE_RISE;
         sample_limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRIG_LEVEL:   trig_level_ff   <= csr_data[DAC_BITS-1:0];
            CSR_TRIG_DELTA:   trig_delta_ff   <= csr_data[DAC_BITS-1:0];
            CSR_TRIG_EDGE:    trig_edge_ff    <= csr_data[1:0];
            CSR_SAMPLE_LIMIT: sample_limit_ff <= csr_data[LIMIT_W-1:0];
         endcase
      end
   end

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         FSM_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_TICK:    fsm_in = bump.en ? FSM_BUMP : FSM_IDLE;
                  OP_READ:    fsm_in = FSM_READ;
                  OP_RESTART: fsm_in = FSM_CLEAR;
                  OP_NONE:    fsm_in = FSM_IDLE;
               endcase
            end
         end
         FSM_BUMP:  fsm_in = FSM_IDLE;
         FSM_READ:  fsm_in = FSM_IDLE;
         FSM_CLEAR: fsm_in = (clr_idx_ff == {HIST_AW{1'b1}}) ? FSM_IDLE : FSM_CLEAR;
      endcase
   end

   assign sat_count  = (&rd_data) ? rd_data : rd_data + COUNT_WIDTH'(1);
   assign rd_addr    = (op == OP_READ) ? req_bin_index : bump.bin;
   assign clr_idx_in = (fsm_ff == FSM_CLEAR) ? clr_idx_ff + HIST_AW'(1) : clr_idx_ff;

   // outputs of the sequencer
   always_comb begin
      wr_en                = 1'b0;
      wr_addr              = clr_idx_ff;
      wr_data              = '0;
      push                 = 1'b0;
      new_rsp.dac_code     = cur_code;
      new_rsp.sample_valid = 1'b0;
      new_rsp.sample_value = '0;
      new_rsp.run_status   = status_next;
      new_rsp.bin_count    = '0;
      unique case (fsm_ff)
         FSM_IDLE: begin
            if (accept && (op != OP_READ)) begin
               push = 1'b1;
               if (op == OP_TICK) begin
                  new_rsp.dac_code     = next_code;
                  new_rsp.sample_valid = done;
                  new_rsp.sample_value = done ? sample : '0;
               end
            end
         end
         FSM_BUMP: begin
            // read data of the bin arrived; write back the saturated count
            wr_en   = 1'b1;
            wr_addr = bump_bin_ff;
            wr_data = sat_count;
         end
         FSM_READ: begin
            push              = 1'b1;
            new_rsp.bin_count = rd_data;
         end
         FSM_CLEAR: begin
            wr_en = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff     <= FSM_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         fsm_ff     <= fsm_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bump_bin_ff <= bump.bin;
      end
   end

   // two-entry result queue: head drives the ports, skid holds the next one
   assign pop      = rsp_valid && !rsp_stall;
   assign rsp_valid = (q_cnt_ff != 2'd0);
   assign q_cnt_in = q_cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
      end else begin
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (q_cnt_ff == 2'd2) begin
            head_ff <= skid_ff;
         end
         if (push && (q_cnt_ff == 2'd1)) begin
            head_ff <= new_rsp;
         end
         if (push && (q_cnt_ff == 2'd2)) begin
            skid_ff <= new_rsp;
         end
      end else if (push) begin
         if (q_cnt_ff == 2'd0) begin
            head_ff <= new_rsp;
         end else begin
            skid_ff <= new_rsp;
         end
      end
   end

   assign rsp_dac_code     = head_ff.dac_code;
   assign rsp_sample_valid = head_ff.sample_valid;
   assign rsp_sample_value = head_ff.sample_value;
   assign rsp_run_status   = head_ff.run_status;
   assign rsp_bin_count    = head_ff.bin_count;

endmodule

/* hw/rtl/sath_checker.sv */
// Port-level checks of the triggered histogram converter, bound to the top level
`timescale 1ns / 1ps
`include "sar_adc_triggered_histogram_assert.svh"
module sath_checker #(
   parameter int DAC_BITS    = sath_pkg::DAC_BITS_DEF,
   parameter int COUNT_WIDTH = sath_pkg::COUNT_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [1:0]             req_operation,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [DAC_BITS-1:0]    rsp_dac_code,
   input logic                   rsp_sample_valid,
   input logic [DAC_BITS-1:0]    rsp_sample_value,
   input logic [COUNT_WIDTH-1:0] rsp_bin_count
);
   import sath_pkg::*;

   // a stalled result holds
   `SATH_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_dac_code) && $stable(rsp_bin_count))
   // no sample value without a finished conversion
   `SATH_ASSERT_IMP(a_sample_zero, clock, reset, rsp_valid && !rsp_sample_valid, rsp_sample_value == '0)
   // a finished conversion never carries a bin count
   `SATH_ASSERT_IMP(a_count_zero, clock, reset, rsp_valid && rsp_sample_valid, rsp_bin_count == '0)
   // a restart transfer starts the clearing pass
   `SATH_ASSERT_NXT(a_restart_stall, clock, reset, req_valid && !req_stall && (req_operation == OP_RESTART), req_stall)

endmodule

bind sar_adc_triggered_histogram sath_checker #(
   .DAC_BITS    (DAC_BITS),
   .COUNT_WIDTH (COUNT_WIDTH)
) u_sath_checker (.*);
